// File: rtl/core/btc_pkg.sv
// Shared digit codes and queue sizing for the balanced ternary converter.
package btc_pkg;

	localparam logic [1:0] CODE_ZERO  = 2'd0;
	localparam logic [1:0] CODE_PLUS  = 2'd1;
	localparam logic [1:0] CODE_MINUS = 2'd2;
	localparam logic [1:0] CODE_NONE  = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;

endpackage

// File: rtl/core/btc_front.sv
// Front end: accepts a request and extracts its balanced ternary digits, least significant first.
module btc_front #(
	parameter int VALUE_BITS = 10,
	parameter int MAX_DIGITS = 7,
	parameter int CNT_W      = 3,
	parameter int IDX_W      = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [VALUE_BITS-1:0]       value,
	output logic                        busy,
	input  logic                        q_full,
	output logic                        q_push,
	output logic [MAX_DIGITS-1:0][1:0]  q_digits,
	output logic [CNT_W-1:0]            q_count
);
	import btc_pkg::*;

	localparam int SHIFT = VALUE_BITS + 2;
	localparam logic [63:0] RECIP_WIDE = ((64'd1 << SHIFT) / 64'd3) + 64'd1;
	localparam logic [VALUE_BITS:0] RECIP = RECIP_WIDE[VALUE_BITS:0];
	localparam int PROD_W = 2 * VALUE_BITS + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]                   state_q;
	logic [VALUE_BITS-1:0]        v_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [MAX_DIGITS-1:0][1:0]   dig_q;

	logic [PROD_W-1:0]            prod;
	logic [VALUE_BITS-2:0]        quot;
	logic [VALUE_BITS-1:0]        quot_ext;
	logic [VALUE_BITS-1:0]        three_q;
	logic [VALUE_BITS-1:0]        rem_full;
	logic [1:0]                   rem;
	logic                         conv_done;

	assign prod      = PROD_W'(v_q) * PROD_W'(RECIP);
	assign quot      = prod[PROD_W-1:SHIFT];
	assign quot_ext  = {1'b0, quot};
	assign three_q   = quot_ext + {quot, 1'b0};
	assign rem_full  = v_q - three_q;
	assign rem       = rem_full[1:0];
	assign conv_done = (v_q == '0) || (cnt_q == CNT_W'(MAX_DIGITS));

	assign busy     = (state_q != ST_IDLE);
	assign q_push   = (state_q == ST_PUSH) && !q_full;
	assign q_digits = dig_q;
	assign q_count  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			v_q   <= value;
			cnt_q <= (value == '0) ? CNT_W'(1) : '0;
			if (value == '0) begin
				dig_q[0] <= CODE_ZERO;
			end
		end else if (state_q == ST_CONV && !conv_done) begin
			case (rem)
				2'd2: begin
					dig_q[cnt_q[IDX_W-1:0]] <= CODE_MINUS;
					v_q <= quot_ext + VALUE_BITS'(1);
				end
				2'd1: begin
					dig_q[cnt_q[IDX_W-1:0]] <= CODE_PLUS;
					v_q <= quot_ext;
				end
				default: begin
					dig_q[cnt_q[IDX_W-1:0]] <= CODE_ZERO;
					v_q <= quot_ext;
				end
			endcase
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (cnt_q != '0))
		else $error("front pushes an empty digit run");

endmodule

// File: rtl/core/btc_queue.sv
// Short queue of converted digit runs between front and back end.
module btc_queue #(
	parameter int MAX_DIGITS = 7,
	parameter int CNT_W      = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [MAX_DIGITS-1:0][1:0]  wr_digits,
	input  logic [CNT_W-1:0]            wr_count,
	input  logic                        pop,
	output logic                        full,
	output logic                        empty,
	output logic [MAX_DIGITS-1:0][1:0]  rd_digits,
	output logic [CNT_W-1:0]            rd_count
);
	import btc_pkg::*;

	logic [MAX_DIGITS-1:0][1:0] dig_mem [QUEUE_DEPTH];
	logic [CNT_W-1:0]           cnt_mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]     wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]     rd_ptr_q;
	logic [QUEUE_PTR_W:0]       fill_q;

	assign full      = (fill_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign empty     = (fill_q == '0);
	assign rd_digits = dig_mem[rd_ptr_q];
	assign rd_count  = cnt_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			dig_mem[wr_ptr_q] <= wr_digits;
			cnt_mem[wr_ptr_q] <= wr_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QUEUE_PTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QUEUE_PTR_W+1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

// File: rtl/core/btc_back.sv
// Back end: emits each queued digit run, most significant digit first.
module btc_back #(
	parameter int MAX_DIGITS = 7,
	parameter int CNT_W      = 3,
	parameter int IDX_W      = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  logic [MAX_DIGITS-1:0][1:0]  q_digits,
	input  logic [CNT_W-1:0]            q_count,
	output logic                        q_pop,
	output logic                        valid,
	output logic [1:0]                  digit,
	output logic                        last_digit
);
	logic                        active_q;
	logic [IDX_W-1:0]            idx_q;
	logic [MAX_DIGITS-1:0][1:0]  dig_q;
	logic                        valid_q;
	logic [1:0]                  digit_q;
	logic                        last_q;
	logic                        pop;

	assign pop         = !q_empty && (!active_q || idx_q == '0);
	assign q_pop       = pop;
	assign valid       = valid_q;
	assign digit       = digit_q;
	assign last_digit  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
			end else if (active_q && idx_q == '0) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			digit_q <= dig_q[idx_q];
			last_q  <= (idx_q == '0);
		end
		if (pop) begin
			dig_q <= q_digits;
			idx_q <= IDX_W'(q_count - CNT_W'(1));
		end else if (active_q) begin
			idx_q <= idx_q - IDX_W'(1);
		end
	end

endmodule

// File: rtl/core/balanced_ternary_converter.sv
// Top level: binary to balanced ternary converter, front end, queue and back end.
// Front end extracts the digits one at a time in its divide-by-three loop; a zero request
// gets its single zero digit without the loop. busy is high from acceptance until the
// run is queued; the front end then takes a new request while the back end still emits
// earlier runs. Sustained rate is set by the front end's divide-by-three loop.
// Asynchronous active-low reset clears state, queue and strobe; the receiver cannot stall.
module balanced_ternary_converter #(
	parameter int VALUE_BITS = 10,
	parameter int MAX_DIGITS = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_BITS-1:0]  value,
	output logic                   valid,
	output logic [1:0]             digit,
	output logic                   last_digit
);
	import btc_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = $clog2(MAX_DIGITS);

	logic                       q_push;
	logic                       q_full;
	logic                       q_pop;
	logic [MAX_DIGITS-1:0][1:0] f_digits;
	logic [CNT_W-1:0]           f_count;
	logic [MAX_DIGITS-1:0][1:0] b_digits;
	logic [CNT_W-1:0]           b_count;
	logic                       q_empty;

	btc_front #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS),
		.CNT_W      (CNT_W),
		.IDX_W      (IDX_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.value    (value),
		.busy     (busy),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_digits (f_digits),
		.q_count  (f_count)
	);

	btc_queue #(
		.MAX_DIGITS (MAX_DIGITS),
		.CNT_W      (CNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_digits (f_digits),
		.wr_count  (f_count),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.rd_digits (b_digits),
		.rd_count  (b_count)
	);

	btc_back #(
		.MAX_DIGITS (MAX_DIGITS),
		.CNT_W      (CNT_W),
		.IDX_W      (IDX_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_digits   (b_digits),
		.q_count    (b_count),
		.q_pop      (q_pop),
		.valid      (valid),
		.digit      (digit),
		.last_digit (last_digit)
	);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without going busy");

	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last_digit) |=> valid)
		else $error("digit run broken before its last digit");

	a_digit_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (digit != CODE_NONE))
		else $error("invalid digit code emitted");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the balanced ternary converter: directed and random requests.
module testbench;
	import btc_pkg::*;

	localparam int VALUE_BITS  = 10;
	localparam int MAX_DIGITS  = 7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 30;

	typedef struct {
		logic [1:0] code;
		logic       last;
	} digit_rec_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [VALUE_BITS-1:0] value;
	logic                  valid;
	logic [1:0]            digit;
	logic                  last_digit;

	digit_rec_t pending_digits [$];
	int         idle_pct;
	int         fail_count;
	int         cycle_count;

	balanced_ternary_converter #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_DIGITS(MAX_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.valid(valid),
		.digit(digit),
		.last_digit(last_digit)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void predict_digits(input logic [VALUE_BITS-1:0] v);
		int unsigned rest;
		logic [1:0]  lsd_first [$];
		digit_rec_t  rec;
		rest = 32'(v);
		if (rest == 0) begin
			rec.code = CODE_ZERO;
			rec.last = 1'b1;
			pending_digits.push_back(rec);
			return;
		end
		while (rest > 0 && lsd_first.size() < MAX_DIGITS) begin
			if (rest % 3 == 2) begin
				lsd_first.push_back(CODE_MINUS);
				rest = rest / 3 + 1;
			end else if (rest % 3 == 1) begin
				lsd_first.push_back(CODE_PLUS);
				rest = rest / 3;
			end else begin
				lsd_first.push_back(CODE_ZERO);
				rest = rest / 3;
			end
		end
		for (int k = lsd_first.size() - 1; k >= 0; k--) begin
			rec.code = lsd_first[k];
			rec.last = (k == 0);
			pending_digits.push_back(rec);
		end
	endfunction

	task automatic send_request(input logic [VALUE_BITS-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		value = v;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_digits(v);
	endtask

	function automatic logic [VALUE_BITS-1:0] random_value();
		if ($urandom_range(3) == 0)
			return VALUE_BITS'($urandom_range(40));
		return VALUE_BITS'($urandom_range(1023));
	endfunction

	task automatic test_directed_values();
		int unsigned picks [$];
		picks = '{0, 1, 2, 3, 4, 5, 12, 13, 14, 39, 40, 41, 120, 121, 122,
			363, 364, 365, 341, 682, 512, 729, 1022, 1023};
		idle_pct = 0;
		foreach (picks[i]) send_request(VALUE_BITS'(picks[i]));
	endtask

	task automatic test_random_sparse_gaps();
		idle_pct = 14;
		repeat (80) send_request(random_value());
	endtask

	task automatic test_random_dense_gaps();
		idle_pct = 88;
		repeat (80) send_request(random_value());
	endtask

	task automatic test_random_back_to_back();
		idle_pct = 0;
		repeat (90) send_request(random_value());
	endtask

	always @(posedge clk) begin : check_digits
		digit_rec_t want;
		if (arst_n && valid) begin
			if (pending_digits.size() == 0) begin
				$error("unexpected digit: digit=%0d last_digit=%0d", digit, last_digit);
				fail_count++;
			end else begin
				want = pending_digits.pop_front();
				if (digit !== want.code) begin
					$error("digit: expected %0d, actual %0d", want.code, digit);
					fail_count++;
				end
				if (last_digit !== want.last) begin
					$error("last_digit: expected %0d, actual %0d", want.last, last_digit);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** balanced_ternary_converter: FAILED **");
			$finish;
		end
	end

	initial begin
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_directed_values();
		test_random_sparse_gaps();
		test_random_dense_gaps();
		test_random_back_to_back();

		@(negedge clk);
		start = 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_digits.size() == 0)
			$display("** balanced_ternary_converter: PASSED **");
		else
			$display("** balanced_ternary_converter: FAILED **");
		$finish;
	end

endmodule
